@@ design/sadsr_pkg.sv @@
package sadsr_pkg;

    // event kinds on the input tuser
    localparam logic [2:0] REQ_PRESS      = 3'd0;
    localparam logic [2:0] REQ_KEY_UP     = 3'd1;
    localparam logic [2:0] REQ_PEDAL_DOWN = 3'd2;
    localparam logic [2:0] REQ_PEDAL_UP   = 3'd3;
    localparam logic [2:0] REQ_QUERY      = 3'd4;

    // register indexes on the APB port
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    localparam int TICK_W = 24;   // phase length registers
    localparam int AMP_W  = 17;   // Q16 level, 0..65536
    localparam logic [AMP_W-1:0] Q16_ONE = 17'h10000;
    localparam logic [AMP_W-1:0] AMP_RST = 17'h10000;

    // shared divider: 42-bit numerator, 24-bit divisor, 18 quotient bits, 2 per cycle
    localparam int DIV_NW    = 42;
    localparam int DIV_DW    = 24;
    localparam int DIV_QW    = 18;
    localparam int DIV_STEPS = DIV_QW / 2;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic active;    // a press has been seen
        logic pending;   // release time not settled yet
    } t_flags;

endpackage

@@ design/sadsr_queue.sv @@
module sadsr_queue #(
    parameter int WIDTH = 66
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [PW:0]      r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;
    assign o_data    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ design/sadsr_front.sv @@
module sadsr_front #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_req,
    input  logic [31:0]           i_time,
    output logic                  o_push,
    input  logic                  i_full,
    output sadsr_pkg::t_flags     o_flags,
    output logic [TIME_WIDTH-1:0] o_e,
    output logic [TIME_WIDTH-1:0] o_tr
);

    localparam int TW = TIME_WIDTH;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_OFS  = 2'd1;
    localparam logic [1:0] F_SEL  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic          r_active;
    logic          r_krel;
    logic          r_pheld;
    logic          r_prel;
    logic [TW-1:0] r_press;
    logic [TW-1:0] r_ktime;
    logic [TW-1:0] r_ptime;
    logic [TW-1:0] r_t;
    logic [TW-1:0] r_dt;
    logic [TW-1:0] r_dk;
    logic [TW-1:0] r_dp;
    logic [TW-1:0] r_dr;
    logic          r_settled;
    logic [63:0]   w_t64;
    logic [TW-1:0] w_t;
    logic          w_accept;
    logic          w_released;

    assign w_t64    = {32'd0, i_time};
    assign w_t      = w_t64[TW-1:0];
    assign o_ready  = (r_state == F_IDLE);
    assign w_accept = o_ready && i_valid;

    // settled release at or before now: level froze at dr, release runs for dt - dr
    assign w_released     = r_settled && (r_dr <= r_dt);
    assign o_push         = (r_state == F_PUSH);
    assign o_flags.active = r_active;
    assign o_flags.pending = !r_settled;
    assign o_e            = w_released ? r_dr : r_dt;
    assign o_tr           = w_released ? (r_dt - r_dr) : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = F_OFS;
                end
            end
            F_OFS:  n_state = F_SEL;
            F_SEL:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_active <= 1'b0;
            r_krel   <= 1'b0;
            r_pheld  <= 1'b0;
            r_prel   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                case (i_req)
                    sadsr_pkg::REQ_PRESS: begin
                        r_active <= 1'b1;
                        r_krel   <= 1'b0;
                        r_pheld  <= 1'b0;
                        r_prel   <= 1'b0;
                    end
                    sadsr_pkg::REQ_KEY_UP: begin
                        r_krel <= 1'b1;
                    end
                    sadsr_pkg::REQ_PEDAL_DOWN: begin
                        // pedal only catches a note whose key is still down
                        if (!r_krel) begin
                            r_pheld <= 1'b1;
                            r_prel  <= 1'b0;
                        end
                    end
                    sadsr_pkg::REQ_PEDAL_UP: begin
                        if (r_pheld && !r_prel) begin
                            r_prel <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_t <= w_t;
            case (i_req)
                sadsr_pkg::REQ_PRESS: begin
                    r_press <= w_t;
                    r_ktime <= '0;
                    r_ptime <= '0;
                end
                sadsr_pkg::REQ_KEY_UP: begin
                    r_ktime <= w_t;
                end
                sadsr_pkg::REQ_PEDAL_UP: begin
                    if (r_pheld && !r_prel) begin
                        r_ptime <= w_t;
                    end
                end
                default: begin
                end
            endcase
        end
        if (r_state == F_OFS) begin
            r_dt <= r_t - r_press;
            r_dk <= r_ktime - r_press;
            r_dp <= r_ptime - r_press;
        end
        if (r_state == F_SEL) begin
            r_settled <= r_krel && (!r_pheld || r_prel);
            // later of key and pedal release, ties to the pedal
            r_dr      <= (r_pheld && !(r_dp < r_dk)) ? r_dp : r_dk;
        end
    end

endmodule

@@ design/sadsr_div.sv @@
module sadsr_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [sadsr_pkg::DIV_NW-1:0]     i_num,
    input  logic [sadsr_pkg::DIV_DW-1:0]     i_den,
    output logic                             o_done,
    output logic [sadsr_pkg::DIV_QW-1:0]     o_quot
);

    localparam int NW = sadsr_pkg::DIV_NW;
    localparam int DW = sadsr_pkg::DIV_DW;
    localparam int QW = sadsr_pkg::DIV_QW;
    localparam int CW = sadsr_pkg::DIV_CW;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_nq;     // numerator bits out at the top, quotient bits in below
    logic [DW:0]   w_s1;
    logic [DW:0]   w_s2;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic nb,
                                             input logic [DW-1:0] den);
        logic [DW:0] t;
        logic [DW:0] d;
        logic [DW:0] s;
        t = {rem, nb};
        d = {1'b0, den};
        s = t - d;
        if (t >= d) begin
            div_step = {1'b1, s[DW-1:0]};
        end else begin
            div_step = {1'b0, t[DW-1:0]};
        end
    endfunction

    assign w_s1   = div_step(r_rem, r_nq[QW-1], r_den);
    assign w_s2   = div_step(w_s1[DW-1:0], r_nq[QW-2], r_den);
    assign o_done = r_done;
    assign o_quot = r_nq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(sadsr_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NW-1:QW];
            r_nq  <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_s2[DW-1:0];
            r_nq  <= {r_nq[QW-3:0], w_s1[DW], w_s2[DW]};
        end
    end

endmodule

@@ design/sadsr_back.sv @@
module sadsr_back #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_pop,
    input  sadsr_pkg::t_flags                 i_flags,
    input  logic [TIME_WIDTH-1:0]             i_e,
    input  logic [TIME_WIDTH-1:0]             i_tr,
    input  logic [sadsr_pkg::TICK_W-1:0]      i_attack,
    input  logic [sadsr_pkg::TICK_W-1:0]      i_decay,
    input  logic [sadsr_pkg::AMP_W-1:0]       i_sustain,
    input  logic [sadsr_pkg::TICK_W-1:0]      i_release,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic [sadsr_pkg::AMP_W-1:0]       o_amp,
    output logic                              o_pending
);

    localparam int TK = sadsr_pkg::TICK_W;
    localparam int AW = sadsr_pkg::AMP_W;
    localparam int NW = sadsr_pkg::DIV_NW;
    localparam int QW = sadsr_pkg::DIV_QW;
    localparam int PW = TK + AW;
    localparam int CW = (TIME_WIDTH > TK) ? TIME_WIDTH : TK;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP1 = 4'd1;
    localparam logic [3:0] ST_PREP2 = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_ATT   = 4'd4;
    localparam logic [3:0] ST_ATT_W = 4'd5;
    localparam logic [3:0] ST_DEC   = 4'd6;
    localparam logic [3:0] ST_DEC_W = 4'd7;
    localparam logic [3:0] ST_REL   = 4'd8;
    localparam logic [3:0] ST_REL_W = 4'd9;
    localparam logic [3:0] ST_SUM   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0]    r_state;
    logic [CW-1:0] r_e;
    logic [CW-1:0] r_tr;
    logic [CW-1:0] r_ex;
    logic [CW-1:0] w_a;
    logic [CW-1:0] w_d;
    logic [CW-1:0] w_r;
    logic [TK-1:0] r_ta;
    logic [TK-1:0] r_td;
    logic          r_ege;
    logic          r_full;
    logic          r_rdiv;
    logic [AW-1:0] r_drop;
    logic [AW-1:0] w_smin;
    logic [PW-1:0] r_prod;
    logic [AW-1:0] r_att;
    logic [AW-1:0] r_dec;
    logic [AW-1:0] r_rel;
    logic [AW-1:0] r_amp;
    logic          r_pend;
    logic [AW+1:0] w_sum;
    logic          w_dstart;
    logic [NW-1:0] w_dnum;
    logic [TK-1:0] w_dden;
    logic          w_ddone;
    logic [QW-1:0] w_dquot;

    assign w_a  = CW'(i_attack);
    assign w_d  = CW'(i_decay);
    assign w_r  = CW'(i_release);
    assign w_smin = i_sustain[AW-1] ? sadsr_pkg::Q16_ONE : i_sustain;
    assign w_sum  = (AW+2)'(r_att) - (AW+2)'(r_dec) - (AW+2)'(r_rel);

    assign o_pop       = (r_state == ST_IDLE) && i_valid;
    assign o_res_valid = (r_state == ST_OUT);
    assign o_amp       = r_amp;
    assign o_pending   = r_pend;

    always_comb begin
        w_dstart = 1'b0;
        w_dnum   = '0;
        w_dden   = '0;
        case (r_state)
            ST_ATT: begin
                w_dstart = (i_attack != '0);
                w_dnum   = NW'({r_ta, 16'd0});
                w_dden   = i_attack;
            end
            ST_DEC: begin
                w_dstart = (i_decay != '0);
                w_dnum   = NW'(r_prod);
                w_dden   = i_decay;
            end
            ST_REL: begin
                w_dstart = !r_full && r_rdiv;
                w_dnum   = NW'({r_tr[TK-1:0], 16'd0});
                w_dden   = i_release;
            end
            default: begin
            end
        endcase
    end

    sadsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_ddone),
        .o_quot  (w_dquot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_state <= i_flags.active ? ST_PREP1 : ST_OUT;
                    end
                end
                ST_PREP1: r_state <= ST_PREP2;
                ST_PREP2: r_state <= ST_MUL;
                ST_MUL:   r_state <= ST_ATT;
                ST_ATT:   r_state <= (i_attack != '0) ? ST_ATT_W : ST_DEC;
                ST_ATT_W: begin
                    if (w_ddone) begin
                        r_state <= ST_DEC;
                    end
                end
                ST_DEC:   r_state <= (i_decay != '0) ? ST_DEC_W : ST_REL;
                ST_DEC_W: begin
                    if (w_ddone) begin
                        r_state <= ST_REL;
                    end
                end
                ST_REL:   r_state <= (!r_full && r_rdiv) ? ST_REL_W : ST_SUM;
                ST_REL_W: begin
                    if (w_ddone) begin
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM:   r_state <= ST_OUT;
                ST_OUT: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_e    <= CW'(i_e);
                r_tr   <= CW'(i_tr);
                r_pend <= i_flags.active && i_flags.pending;
                r_amp  <= '0;
            end
            ST_PREP1: begin
                r_ta   <= (r_e < w_a) ? r_e[TK-1:0] : i_attack;
                r_ege  <= (r_e >= w_a);
                r_ex   <= (r_e > w_a) ? (r_e - w_a) : '0;
                r_drop <= sadsr_pkg::Q16_ONE - w_smin;
                r_full <= (r_tr != '0) && ((i_release == '0) || (r_tr >= w_r));
                r_rdiv <= (r_tr != '0) && (i_release != '0) && (r_tr < w_r);
            end
            ST_PREP2: begin
                r_td <= (r_ex > w_d) ? i_decay : r_ex[TK-1:0];
            end
            ST_MUL: begin
                r_prod <= PW'(r_td) * PW'(r_drop);
            end
            ST_ATT: begin
                r_att <= sadsr_pkg::Q16_ONE;
            end
            ST_ATT_W: begin
                r_att <= w_dquot[AW-1:0];
            end
            ST_DEC: begin
                r_dec <= r_ege ? r_drop : '0;
            end
            ST_DEC_W: begin
                r_dec <= w_dquot[AW-1:0];
            end
            ST_REL: begin
                r_rel <= r_full ? sadsr_pkg::Q16_ONE : '0;
            end
            ST_REL_W: begin
                r_rel <= w_dquot[AW-1:0];
            end
            ST_SUM: begin
                r_amp <= w_sum[AW+1] ? '0 : w_sum[AW-1:0];
            end
            default: begin
            end
        endcase
    end

endmodule

@@ design/sustain_aware_adsr_envelope_top.sv @@
// Linear ADSR envelope for one voice with sustain-pedal release rules. Each beat on
// the input stream is a timestamped event (tuser: press, key release, pedal down,
// pedal up, query; anything else is a query) and gives exactly one output beat with
// the Q16 amplitude at that time and a flag that is set while the release time is
// still open. A front end applies the event to the voice state and works out the
// time offsets; a two-entry queue hands the job to a back end that computes the
// attack, decay and release parts with one shared radix-4 divider (9 iterations,
// then a done strobe) and a 24x17 multiplier. The back end runs a division only
// where a phase needs one and answers an event while no note has been pressed
// directly; that sequencer and its divider set the sustained rate. Results sit in
// an output register, so a stalled output does not hold up new events until the
// queue fills. Registers written over APB: 0x0 attack ticks, 0x4 decay ticks, 0x8
// sustain level (Q16), 0xC release ticks. They are to be written only while the
// block is idle; the block itself does not enforce this.
module sustain_aware_adsr_envelope_top #(
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] event_time
    input  logic [2:0]  i_s_tuser,   // [2:0] req_type
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [16:0] amplitude, [17] release_pending, rest zero
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TK = sadsr_pkg::TICK_W;
    localparam int AW = sadsr_pkg::AMP_W;
    localparam int FW = $bits(sadsr_pkg::t_flags);
    localparam int QW = FW + 2 * TIME_WIDTH;

    // configuration
    logic [TK-1:0] r_attack;
    logic [TK-1:0] r_decay;
    logic [AW-1:0] r_sustain;
    logic [TK-1:0] r_release;
    logic          w_cfg_wr;

    // front to queue
    logic                    w_f_push;
    sadsr_pkg::t_flags       w_f_flags;
    logic [TIME_WIDTH-1:0]   w_f_e;
    logic [TIME_WIDTH-1:0]   w_f_tr;
    logic                    w_q_full;

    // queue to back
    logic                    w_q_valid;
    logic                    w_q_pop;
    logic [QW-1:0]           w_q_data;
    sadsr_pkg::t_flags       w_b_flags;
    logic [TIME_WIDTH-1:0]   w_b_e;
    logic [TIME_WIDTH-1:0]   w_b_tr;

    // back to output register
    logic          w_res_valid;
    logic [AW-1:0] w_res_amp;
    logic          w_res_pend;
    logic          w_out_free;
    logic          r_m_tvalid;
    logic [23:0]   r_m_tdata;

    // ---- APB: no wait states, write on the access phase ----
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= '0;
            r_decay   <= '0;
            r_sustain <= sadsr_pkg::AMP_RST;
            r_release <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                sadsr_pkg::REG_ATTACK:  r_attack  <= pwdata[TK-1:0];
                sadsr_pkg::REG_DECAY:   r_decay   <= pwdata[TK-1:0];
                sadsr_pkg::REG_SUSTAIN: r_sustain <= pwdata[AW-1:0];
                sadsr_pkg::REG_RELEASE: r_release <= pwdata[TK-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sadsr_pkg::REG_ATTACK:  prdata = 32'(r_attack);
            sadsr_pkg::REG_DECAY:   prdata = 32'(r_decay);
            sadsr_pkg::REG_SUSTAIN: prdata = 32'(r_sustain);
            sadsr_pkg::REG_RELEASE: prdata = 32'(r_release);
            default:                prdata = '0;
        endcase
    end

    // ---- front end: voice state and offsets ----
    sadsr_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_req   (i_s_tuser),
        .i_time  (i_s_tdata),
        .o_push  (w_f_push),
        .i_full  (w_q_full),
        .o_flags (w_f_flags),
        .o_e     (w_f_e),
        .o_tr    (w_f_tr)
    );

    // ---- job queue ----
    sadsr_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_data  ({w_f_flags, w_f_e, w_f_tr}),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data)
    );

    assign w_b_flags = w_q_data[QW-1 -: FW];
    assign w_b_e     = w_q_data[2*TIME_WIDTH-1 -: TIME_WIDTH];
    assign w_b_tr    = w_q_data[TIME_WIDTH-1:0];

    // ---- back end: level arithmetic ----
    sadsr_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .o_pop       (w_q_pop),
        .i_flags     (w_b_flags),
        .i_e         (w_b_e),
        .i_tr        (w_b_tr),
        .i_attack    (r_attack),
        .i_decay     (r_decay),
        .i_sustain   (r_sustain),
        .i_release   (r_release),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_out_free),
        .o_amp       (w_res_amp),
        .o_pending   (w_res_pend)
    );

    // ---- output register ----
    assign w_out_free = !r_m_tvalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_out_free) begin
            r_m_tvalid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res_valid) begin
            r_m_tdata <= {6'd0, w_res_pend, w_res_amp};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // ---- checks ----
    a_amp_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[AW-1:0] <= sadsr_pkg::Q16_ONE))
        else $error("amplitude above full level");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_out_free) |=> (w_res_valid && $stable(w_res_amp)))
        else $error("back end dropped a result while output was busy");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("back end took a job from an empty queue");

endmodule
